// ===== src/selm_pkg.sv =====
`timescale 1ns / 1ps

package selm_pkg;

  // Defaults for the top-level parameters
  localparam int QueueDepthDef   = 16;
  localparam int ThreadIdBitsDef = 6;
  localparam int CountBitsDef    = 16;

  // Fixed width of the reported hold count
  localparam int HoldOutBits = 16;

  // Result status codes
  typedef enum logic [2:0] {
    ST_GRANTED     = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_REFUSED     = 3'd2,
    ST_QUEUE_FULL  = 3'd3,
    ST_COUNT_LIMIT = 3'd4,
    ST_RELEASED    = 3'd5,
    ST_WAITER_GRNT = 3'd6,
    ST_REL_ERROR   = 3'd7
  } status_t;

  // Request codes
  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;
  localparam logic MODE_SHARED = 1'b0;
  localparam logic MODE_EXCL   = 1'b1;

  // Queue control from the sequencer to the waiter chain
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

// ===== src/selm_cell.sv =====
`timescale 1ns / 1ps

module selm_cell import selm_pkg::*; #(
  parameter int ThreadIdBits = ThreadIdBitsDef
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    shift,
  input  logic [ThreadIdBits-1:0] load_id,
  input  logic                    load_mode,
  input  logic [ThreadIdBits-1:0] nbr_id,
  input  logic                    nbr_mode,
  output logic [ThreadIdBits-1:0] id,
  output logic                    mode
);

  logic [ThreadIdBits-1:0] id_r;
  logic                    mode_r;

  // One waiter slot: take the neighbour's entry on a pop, new entry on a push
  always_ff @(posedge clk) begin
    if (shift) begin
      id_r   <= nbr_id;
      mode_r <= nbr_mode;
    end else if (load) begin
      id_r   <= load_id;
      mode_r <= load_mode;
    end
  end

  assign id   = id_r;
  assign mode = mode_r;

endmodule

// ===== src/selm_queue.sv =====
`timescale 1ns / 1ps

module selm_queue import selm_pkg::*; #(
  parameter int QueueDepth   = QueueDepthDef,
  parameter int ThreadIdBits = ThreadIdBitsDef,
  localparam int UsedBits    = $clog2(QueueDepth + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  q_ctrl_t                 ctrl,
  input  logic [ThreadIdBits-1:0] push_id,
  input  logic                    push_mode,
  output logic [ThreadIdBits-1:0] head_id,
  output logic                    head_mode,
  output logic                    next_mode,
  output logic [UsedBits-1:0]     used
);

  logic [ThreadIdBits-1:0] cell_id   [QueueDepth];
  logic                    cell_mode [QueueDepth];
  logic [UsedBits-1:0]     used_r, used_nxt;

  // Chain of slots, head at slot 0; a pop moves every entry one slot down
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic [ThreadIdBits-1:0] nbr_id;
    logic                    nbr_mode;
    logic                    load;

    if (i == QueueDepth - 1) begin : g_end
      assign nbr_id   = cell_id[i];
      assign nbr_mode = cell_mode[i];
    end else begin : g_mid
      assign nbr_id   = cell_id[i+1];
      assign nbr_mode = cell_mode[i+1];
    end

    // A push lands in the first free slot
    assign load = ctrl.push && (used_r == UsedBits'(i));

    selm_cell #(
      .ThreadIdBits(ThreadIdBits)
    ) u_cell (
      .clk      (clk),
      .load     (load),
      .shift    (ctrl.pop),
      .load_id  (push_id),
      .load_mode(push_mode),
      .nbr_id   (nbr_id),
      .nbr_mode (nbr_mode),
      .id       (cell_id[i]),
      .mode     (cell_mode[i])
    );
  end

  // Fill count
  always_comb begin
    used_nxt = used_r;
    if (ctrl.push) begin
      used_nxt = used_r + UsedBits'(1);
    end else if (ctrl.pop) begin
      used_nxt = used_r - UsedBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  assign head_id   = cell_id[0];
  assign head_mode = cell_mode[0];
  assign next_mode = cell_mode[1];
  assign used      = used_r;

endmodule

// ===== src/shared_exclusive_lock_manager.sv =====
// Shared/exclusive lock manager with a chain of waiter slots.
// The first result is registered from the EXEC state, after the request is captured.
// A new request is taken only when idle (busy low); on release, each waiter granted adds a result,
// and the grant run pops one slot of the waiter chain per cycle. No stall from the receiver.
// Reset (synchronous, active low): lock free, shared mode, no holder, queue empty.
`timescale 1ns / 1ps

module shared_exclusive_lock_manager import selm_pkg::*; #(
  parameter int QueueDepth   = QueueDepthDef,
  parameter int ThreadIdBits = ThreadIdBitsDef,
  parameter int CountBits    = CountBitsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_req_type,
  input  logic [ThreadIdBits-1:0] in_thread_id,
  input  logic                    in_req_mode,
  input  logic                    in_may_wait,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [ThreadIdBits-1:0] out_thread_out,
  output logic                    out_grant_mode,
  output logic [HoldOutBits-1:0]  out_hold_count_out,
  output logic                    out_last
);

  localparam int UsedBits = $clog2(QueueDepth + 1);
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_GRANT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Lock state
  logic                    lock_mode_r, lock_mode_nxt;
  logic [CountBits-1:0]    count_r, count_nxt;
  logic [ThreadIdBits-1:0] holder_id_r, holder_id_nxt;
  logic                    holder_vld_r, holder_vld_nxt;

  // Captured request
  logic                    req_type_r;
  logic [ThreadIdBits-1:0] req_tid_r;
  logic                    req_mode_r;
  logic                    req_wait_r;

  // Result registers
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [ThreadIdBits-1:0] out_tid_r, out_tid_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_mode_r;
  logic [CountBits-1:0]    out_count_r;

  // Waiter chain
  q_ctrl_t                 q_ctrl;
  logic [ThreadIdBits-1:0] q_head_id;
  logic                    q_head_mode;
  logic                    q_next_mode;
  logic [UsedBits-1:0]     q_used;

  logic                    reenter;
  logic [CountBits-1:0]    count_dec;
  logic [CountBits-1:0]    count_inc;

  selm_queue #(
    .QueueDepth  (QueueDepth),
    .ThreadIdBits(ThreadIdBits)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (q_ctrl),
    .push_id  (req_tid_r),
    .push_mode(req_mode_r),
    .head_id  (q_head_id),
    .head_mode(q_head_mode),
    .next_mode(q_next_mode),
    .used     (q_used)
  );

  assign reenter = (lock_mode_r && holder_vld_r && (holder_id_r == req_tid_r)) ||
                   (!lock_mode_r && (req_mode_r == MODE_SHARED) && (q_used == '0));
  assign count_dec = count_r - CountBits'(1);
  assign count_inc = count_r + CountBits'(1);

  // Request sequencer
  always_comb begin
    state_nxt      = state_r;
    lock_mode_nxt  = lock_mode_r;
    count_nxt      = count_r;
    holder_id_nxt  = holder_id_r;
    holder_vld_nxt = holder_vld_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_tid_nxt    = req_tid_r;
    out_last_nxt   = 1'b1;
    q_ctrl         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (req_type_r == REQ_ACQUIRE) begin
          if (count_r == '0) begin
            count_nxt      = CountBits'(1);
            lock_mode_nxt  = req_mode_r;
            holder_vld_nxt = req_mode_r;
            holder_id_nxt  = req_mode_r ? req_tid_r : '0;
            out_status_nxt = ST_GRANTED;
          end else if (reenter) begin
            if (count_r == CountMax) begin
              out_status_nxt = ST_COUNT_LIMIT;
            end else begin
              count_nxt      = count_inc;
              out_status_nxt = ST_GRANTED;
            end
          end else if (!req_wait_r) begin
            out_status_nxt = ST_REFUSED;
          end else if (q_used == UsedBits'(QueueDepth)) begin
            out_status_nxt = ST_QUEUE_FULL;
          end else begin
            q_ctrl.push    = 1'b1;
            out_status_nxt = ST_QUEUED;
          end
        end else begin
          if (count_r == '0) begin
            out_status_nxt = ST_REL_ERROR;
          end else begin
            count_nxt      = count_dec;
            out_status_nxt = ST_RELEASED;
            if (count_dec == '0) begin
              holder_id_nxt  = '0;
              holder_vld_nxt = 1'b0;
              // Lock falls free with waiters: hand over in the following cycles
              if (q_used != '0) begin
                out_last_nxt = 1'b0;
                state_nxt    = S_GRANT;
              end
            end
          end
        end
      end

      S_GRANT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_WAITER_GRNT;
        out_tid_nxt    = q_head_id;
        q_ctrl.pop     = 1'b1;
        if (q_head_mode == MODE_EXCL) begin
          // Exclusive waiter at the head is granted alone
          lock_mode_nxt  = MODE_EXCL;
          count_nxt      = CountBits'(1);
          holder_id_nxt  = q_head_id;
          holder_vld_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          // Shared run: stop at an exclusive waiter, an empty queue or a full count
          lock_mode_nxt = MODE_SHARED;
          count_nxt     = count_inc;
          out_last_nxt  = (q_used == UsedBits'(1)) || (q_next_mode == MODE_EXCL) ||
                          (count_inc == CountMax);
          state_nxt     = out_last_nxt ? S_IDLE : S_GRANT;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and lock state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lock_mode_r  <= 1'b0;
      count_r      <= '0;
      holder_id_r  <= '0;
      holder_vld_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lock_mode_r  <= lock_mode_nxt;
      count_r      <= count_nxt;
      holder_id_r  <= holder_id_nxt;
      holder_vld_r <= holder_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Request capture on transfer, result payload
  always_ff @(posedge clk) begin
    if (start && (state_r == S_IDLE)) begin
      req_type_r <= in_req_type;
      req_tid_r  <= in_thread_id;
      req_mode_r <= in_req_mode;
      req_wait_r <= in_may_wait;
    end
    out_status_r <= out_status_nxt;
    out_tid_r    <= out_tid_nxt;
    out_last_r   <= out_last_nxt;
    out_mode_r   <= lock_mode_nxt;
    out_count_r  <= count_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_thread_out     = out_tid_r;
  assign out_grant_mode     = out_mode_r;
  assign out_hold_count_out = HoldOutBits'(out_count_r);
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  // A request that is taken keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after request transfer");

  // Results of one request come in consecutive cycles
  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a result run");

  // An exclusive hand-over ends the run
  a_excl_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_WAITER_GRNT) && out_grant_mode) |-> out_last)
    else $error("exclusive waiter grant not final");

  // Fill count never passes the chain length
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_used <= UsedBits'(QueueDepth))
    else $error("waiter count beyond depth");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import selm_pkg::*;

  localparam int TidW        = ThreadIdBitsDef;
  localparam int CntW        = CountBitsDef;
  localparam int QDepth      = QueueDepthDef;
  localparam int CountMaxI   = (1 << CntW) - 1;
  localparam int CycleLimit  = 2_000_000;
  localparam int DrainWait   = 40;
  localparam int NestDepth   = 16;
  localparam int RandomItems = 260;

  typedef struct {
    status_t           status;
    logic [TidW-1:0]   tid;
    logic              mode;
    logic [HoldOutBits-1:0] count;
    logic              last;
  } lock_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_req_type;
  logic [TidW-1:0] in_thread_id;
  logic in_req_mode;
  logic in_may_wait;
  logic out_valid;
  logic [2:0] out_status;
  logic [TidW-1:0] out_thread_out;
  logic out_grant_mode;
  logic [HoldOutBits-1:0] out_hold_count_out;
  logic out_last;

  // Shadow of the lock state
  logic            lk_mode;
  logic [CntW-1:0] lk_count;
  logic [TidW-1:0] lk_holder;
  logic            lk_holder_ok;
  logic [TidW-1:0] wait_ids [QDepth];
  logic            wait_modes [QDepth];
  int              wait_head;
  int              wait_tail;
  int              wait_used;

  lock_result_t pending_results[$];
  int  mismatches = 0;
  bit  gaps_on = 1'b1;
  bit  start_low = 1'b1;
  int  burst_left = 0;
  int  cycles = 0;

  shared_exclusive_lock_manager DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_thread_id       (in_thread_id),
    .in_req_mode        (in_req_mode),
    .in_may_wait        (in_may_wait),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_thread_out     (out_thread_out),
    .out_grant_mode     (out_grant_mode),
    .out_hold_count_out (out_hold_count_out),
    .out_last           (out_last)
  );

  always #4 clk = ~clk;

  // Queue one expected result, taking mode and count as they now stand
  task automatic push_result(input status_t st, input logic [TidW-1:0] tid, input logic last);
    lock_result_t r;
    r.status = st;
    r.tid    = tid;
    r.mode   = lk_mode;
    r.count  = HoldOutBits'(lk_count);
    r.last   = last;
    pending_results.push_back(r);
  endtask

  // Work out the results of one accepted request
  task automatic predict_lock(input logic rt, input logic [TidW-1:0] tid, input logic md,
                              input logic mw);
    logic [TidW-1:0] w;
    lock_result_t r;
    if (rt == REQ_ACQUIRE) begin
      if (lk_count == 0) begin
        lk_count     = CntW'(1);
        lk_mode      = md;
        lk_holder_ok = md;
        lk_holder    = md ? tid : '0;
        push_result(ST_GRANTED, tid, 1'b1);
      end else if ((lk_mode == MODE_EXCL && lk_holder_ok && lk_holder == tid) ||
                   (lk_mode == MODE_SHARED && md == MODE_SHARED && wait_used == 0)) begin
        if (lk_count == CntW'(CountMaxI)) begin
          push_result(ST_COUNT_LIMIT, tid, 1'b1);
        end else begin
          lk_count = lk_count + CntW'(1);
          push_result(ST_GRANTED, tid, 1'b1);
        end
      end else if (!mw) begin
        push_result(ST_REFUSED, tid, 1'b1);
      end else if (wait_used >= QDepth) begin
        push_result(ST_QUEUE_FULL, tid, 1'b1);
      end else begin
        wait_ids[wait_tail]   = tid;
        wait_modes[wait_tail] = md;
        wait_tail = (wait_tail + 1) % QDepth;
        wait_used++;
        push_result(ST_QUEUED, tid, 1'b1);
      end
    end else begin
      if (lk_count == 0) begin
        push_result(ST_REL_ERROR, tid, 1'b1);
      end else begin
        lk_count = lk_count - CntW'(1);
        if (lk_count == 0) begin
          lk_holder    = '0;
          lk_holder_ok = 1'b0;
        end
        if (lk_count != 0 || wait_used == 0) begin
          push_result(ST_RELEASED, tid, 1'b1);
        end else begin
          push_result(ST_RELEASED, tid, 1'b0);
          if (wait_modes[wait_head] == MODE_EXCL) begin
            w = wait_ids[wait_head];
            wait_head = (wait_head + 1) % QDepth;
            wait_used--;
            lk_mode      = MODE_EXCL;
            lk_count     = CntW'(1);
            lk_holder    = w;
            lk_holder_ok = 1'b1;
            push_result(ST_WAITER_GRNT, w, 1'b0);
          end else begin
            // grant the run of shared waiters at the head
            while (wait_used != 0 && wait_modes[wait_head] == MODE_SHARED &&
                   lk_count != CntW'(CountMaxI)) begin
              w = wait_ids[wait_head];
              wait_head = (wait_head + 1) % QDepth;
              wait_used--;
              lk_mode  = MODE_SHARED;
              lk_count = lk_count + CntW'(1);
              push_result(ST_WAITER_GRNT, w, 1'b0);
            end
          end
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
    end
  endtask

  // One request transfer, then the sender's burst/gap pacing.
  // Called at a rising edge; returns at a rising edge.
  task automatic send_req(input logic rt, input logic [TidW-1:0] tid, input logic md,
                          input logic mw);
    start        <= 1'b1;
    start_low     = 1'b0;
    in_req_type  <= rt;
    in_thread_id <= tid;
    in_req_mode  <= md;
    in_may_wait  <= mw;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_lock(rt, tid, md, mw);
    if (gaps_on) begin
      if (burst_left == 0) begin
        start    <= 1'b0;
        start_low = 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    mismatches++;
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin : check_results
    lock_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got status %0d thread %0d",
                 $time, out_status, out_thread_out);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_field("status", 16'(want.status), 16'(out_status));
        if (out_thread_out !== want.tid)
          report_field("thread_out", 16'(want.tid), 16'(out_thread_out));
        if (out_grant_mode !== want.mode)
          report_field("grant_mode", 16'(want.mode), 16'(out_grant_mode));
        if (out_hold_count_out !== want.count)
          report_field("hold_count_out", want.count, out_hold_count_out);
        if (out_last !== want.last)
          report_field("last", 16'(want.last), 16'(out_last));
      end
    end
  end

  // Free lock, shared joins, refusals, waiting and an exclusive hand-over
  task automatic test_basic_grants();
    send_req(REQ_RELEASE, 6'd0, MODE_SHARED, 1'b1);   // release of a free lock
    send_req(REQ_ACQUIRE, 6'd63, MODE_SHARED, 1'b0);
    send_req(REQ_ACQUIRE, 6'd5, MODE_SHARED, 1'b0);   // joins the shared hold
    send_req(REQ_ACQUIRE, 6'd9, MODE_EXCL, 1'b0);     // busy, may not wait
    send_req(REQ_ACQUIRE, 6'd9, MODE_EXCL, 1'b1);
    send_req(REQ_ACQUIRE, 6'd10, MODE_SHARED, 1'b1);  // someone waits, so it queues
    send_req(REQ_ACQUIRE, 6'd10, MODE_SHARED, 1'b1);  // same thread queued twice
    send_req(REQ_RELEASE, 6'd33, MODE_EXCL, 1'b0);    // any thread may release
    send_req(REQ_RELEASE, 6'd0, MODE_SHARED, 1'b0);   // hands over to thread 9
  endtask

  // Holder reentry in either mode, shared grant run, mode kept on a free lock
  task automatic test_holder_reentry();
    send_req(REQ_ACQUIRE, 6'd9, MODE_SHARED, 1'b0);
    send_req(REQ_ACQUIRE, 6'd9, MODE_EXCL, 1'b0);
    repeat (3) send_req(REQ_RELEASE, 6'd9, MODE_SHARED, 1'b0);
    repeat (2) send_req(REQ_RELEASE, 6'd10, MODE_SHARED, 1'b1);
    send_req(REQ_ACQUIRE, 6'd0, MODE_EXCL, 1'b0);
    send_req(REQ_RELEASE, 6'd0, MODE_EXCL, 1'b0);     // free, mode stays exclusive
    send_req(REQ_ACQUIRE, 6'd63, MODE_SHARED, 1'b1);
    send_req(REQ_RELEASE, 6'd63, MODE_SHARED, 1'b1);
  endtask

  // Fill the queue with shared waiters, overflow it, then grant them all at once
  task automatic test_queue_full();
    send_req(REQ_ACQUIRE, 6'd1, MODE_EXCL, 1'b1);
    for (int i = 0; i < QDepth; i++)
      send_req(REQ_ACQUIRE, TidW'(i * 4 + 3), MODE_SHARED, 1'b1);
    send_req(REQ_ACQUIRE, 6'd62, MODE_SHARED, 1'b1);
    send_req(REQ_ACQUIRE, 6'd61, MODE_EXCL, 1'b1);
    send_req(REQ_RELEASE, 6'd1, MODE_EXCL, 1'b1);
    repeat (QDepth) send_req(REQ_RELEASE, 6'd2, MODE_SHARED, 1'b0);
  endtask

  // Nest the exclusive hold back to back, refuse and queue others, then unwind
  task automatic test_nesting();
    gaps_on = 1'b0;
    send_req(REQ_ACQUIRE, 6'd42, MODE_EXCL, 1'b0);
    repeat (NestDepth - 1)
      send_req(REQ_ACQUIRE, 6'd42, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    send_req(REQ_ACQUIRE, 6'd42, MODE_SHARED, 1'b0);
    send_req(REQ_ACQUIRE, 6'd7, MODE_SHARED, 1'b0);
    send_req(REQ_ACQUIRE, 6'd3, MODE_SHARED, 1'b1);
    repeat (NestDepth + 1)
      send_req(REQ_RELEASE, TidW'($urandom()), MODE_SHARED, 1'b0);
    send_req(REQ_RELEASE, 6'd3, MODE_SHARED, 1'b0);
    gaps_on = 1'b1;
  endtask

  // Random traffic in chunks, each with its own release rate and pacing
  task automatic test_random_traffic(input int n_items);
    int sent;
    int rel_pct;
    int chunk;
    logic rt;
    logic md;
    logic mw;
    logic [TidW-1:0] tid;
    sent = 0;
    while (sent < n_items) begin
      chunk   = $urandom_range(10, 30);
      rel_pct = $urandom_range(10, 60);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (chunk) begin
        rt = ($urandom_range(0, 99) < rel_pct);
        if (rt == REQ_RELEASE && lk_count == 0 && $urandom_range(0, 3) != 0)
          rt = REQ_ACQUIRE;
        case ($urandom_range(0, 3))
          0: tid = TidW'($urandom());
          1: tid = lk_holder_ok ? lk_holder : TidW'($urandom_range(0, 7));
          default: tid = TidW'($urandom_range(0, 7));
        endcase
        md = 1'($urandom_range(0, 1));
        mw = ($urandom_range(0, 4) != 0);
        send_req(rt, tid, md, mw);
        sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req_type  = REQ_ACQUIRE;
    in_thread_id = '0;
    in_req_mode  = MODE_SHARED;
    in_may_wait  = 1'b0;
    lk_mode      = MODE_SHARED;
    lk_count     = '0;
    lk_holder    = '0;
    lk_holder_ok = 1'b0;
    wait_head    = 0;
    wait_tail    = 0;
    wait_used    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_grants();
    test_holder_reentry();
    test_queue_full();
    test_nesting();
    test_random_traffic(RandomItems);

    if (!start_low) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("shared_exclusive_lock_manager: match");
    end else begin
      $display("shared_exclusive_lock_manager: mismatch");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("shared_exclusive_lock_manager: mismatch");
    $finish;
  end

endmodule
